FILE: design/mbfr_pkg.sv
// Shared types and constants for the MSB-first bit-field reader.
// Word structs for both channels, request and status codes, controller state and
// command/status bundles. No dependencies.
`timescale 1ns / 1ps

package mbfr_pkg;

	localparam logic [2:0] REQ_PUSH         = 3'd0;
	localparam logic [2:0] REQ_UNSIGNED     = 3'd1;
	localparam logic [2:0] REQ_SIGNED       = 3'd2;
	localparam logic [2:0] REQ_ALIGN        = 3'd3;
	localparam logic [2:0] REQ_ALIGNED_BYTE = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	localparam logic [3:0] BYTE_BITS = 4'd8;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic [5:0] field_width;
	} in_word_t;

	typedef struct packed {
		logic [31:0] field_value;
		logic [1:0]  status;
	} out_word_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EVAL,
		CS_SHIFT,
		CS_FIN
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic shift;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic need_fetch;
		logic last_byte;
		logic out_free;
		logic fifo_empty;
		logic partial;
	} dp_status_t;

endpackage

FILE: design/msb_first_bit_field_reader.sv
// Top level of the MSB-first bit-field reader: controller plus datapath.
// Depends on mbfr_pkg, mbfr_ctrl and mbfr_datapath.
//
//   channel | handshake            | word
//   --------+----------------------+--------------------------------------
//   req     | req_valid/req_stall  | req_type, data_byte, field_width
//   rsp     | rsp_valid/rsp_stall  | field_value, status
//
// One request at a time: accept, evaluate, shift once per byte touched by the
// field (none for push, align, errors, width 0; up to 5 for 32 bits), finish.
// The single-read-port byte memory delivers one byte per cycle for shifting.
// A finished word waits in the output register while the next request is taken.
// Reset empties the FIFO and puts the bit offset at a byte boundary.
`timescale 1ns / 1ps

module msb_first_bit_field_reader #(
	parameter int FIFO_DEPTH     = 8,
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mbfr_pkg::in_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mbfr_pkg::out_word_t rsp
);
	import mbfr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	mbfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	mbfr_datapath #(
		.FIFO_DEPTH     (FIFO_DEPTH),
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> rsp.field_value == 32'd0)
		else $error("error word carries nonzero value");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in flight");

	a_partial_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		st.partial |-> !st.fifo_empty)
		else $error("bit offset inside a byte with an empty FIFO");

	a_single_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !cmd.finish)
		else $error("word finished twice");

endmodule

FILE: design/mbfr_ctrl.sv
// Controller state machine for the bit-field reader.
// Sequences accept, evaluate, byte shift and finish. Depends on mbfr_pkg.
`timescale 1ns / 1ps

module mbfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  mbfr_pkg::dp_status_t st,
	output mbfr_pkg::dp_cmd_t    cmd
);
	import mbfr_pkg::*;

	ctl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			CS_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = CS_EVAL;
				end
			end
			CS_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = st.need_fetch ? CS_SHIFT : CS_FIN;
			end
			CS_SHIFT: begin
				cmd.shift = 1'b1;
				if (st.last_byte) begin
					state_nxt = CS_FIN;
				end
			end
			CS_FIN: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = CS_IDLE;
				end
			end
			default: begin
				state_nxt = CS_IDLE;
			end
		endcase
	end

endmodule

FILE: design/mbfr_datapath.sv
// Datapath for the bit-field reader: byte FIFO memory, pointers, bit offset,
// field accumulator and the output register. Depends on mbfr_pkg.
`timescale 1ns / 1ps

module mbfr_datapath #(
	parameter int FIFO_DEPTH     = 8,
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbfr_pkg::in_word_t   req,
	input  logic                 rsp_stall,
	input  mbfr_pkg::dp_cmd_t    cmd,
	output mbfr_pkg::dp_status_t st,
	output logic                 rsp_valid,
	output mbfr_pkg::out_word_t  rsp
);
	import mbfr_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int HW = $clog2(FIFO_DEPTH + 1);
	localparam int AW = HW + 3;
	localparam int CW = (AW > 6) ? AW : 6;

	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [2:0] inc);
		logic [PW:0] s;
		s = {1'b0, p} + (PW+1)'(inc);
		if (s >= (PW+1)'(FIFO_DEPTH)) begin
			s = s - (PW+1)'(FIFO_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	logic [7:0]    mem [FIFO_DEPTH];
	logic [7:0]    rdata_q;
	logic [PW-1:0] head_q, tail_q, rptr_q, raddr, start_ptr;
	logic [HW-1:0] held_q;
	logic [2:0]    off_q;
	in_word_t      req_q;
	out_word_t     rsp_q;
	logic          rsp_valid_q;

	logic [5:0]  w_q, rem_q;
	logic        sgn_q;
	logic [2:0]  pop_q, noff_q, boff_q;
	logic [1:0]  stat_q;
	logic [31:0] acc_q;

	logic [5:0]    wsat, w_eff, end_pos;
	logic [3:0]    sp;
	logic          sgn, chk, short, full, need_fetch;
	logic [AW-1:0] avail;
	logic [1:0]    stat;

	logic [3:0]  room, n;
	logic        last;
	logic [7:0]  shifted, bits;
	logic        sbit;
	logic [31:0] value;

	// request decode and availability check
	always_comb begin
		wsat  = (req_q.field_width > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : req_q.field_width;
		sp    = {1'b0, off_q};
		w_eff = '0;
		sgn   = 1'b0;
		chk   = 1'b0;
		case (req_q.req_type)
			REQ_UNSIGNED: begin
				w_eff = wsat;
				chk   = 1'b1;
			end
			REQ_SIGNED: begin
				w_eff = wsat;
				sgn   = 1'b1;
				chk   = 1'b1;
			end
			REQ_ALIGN: begin
				sp = (off_q != 3'd0) ? BYTE_BITS : 4'd0;
			end
			REQ_ALIGNED_BYTE: begin
				sp    = (off_q != 3'd0) ? BYTE_BITS : 4'd0;
				w_eff = 6'(BYTE_BITS);
				chk   = 1'b1;
			end
			default: begin
			end
		endcase
		avail      = {held_q, 3'b000} - AW'(sp);
		short      = chk && (CW'(w_eff) > CW'(avail));
		full       = (req_q.req_type == REQ_PUSH) && (held_q >= HW'(FIFO_DEPTH));
		end_pos    = 6'(sp) + w_eff;
		start_ptr  = ptr_add(head_q, {2'b00, sp[3]});
		need_fetch = (w_eff != 6'd0) && !short;
		stat       = full ? ST_FULL : (short ? ST_SHORT : ST_OK);
	end

	// one byte per shift step
	always_comb begin
		room    = BYTE_BITS - {1'b0, boff_q};
		last    = rem_q <= 6'(room);
		n       = last ? rem_q[3:0] : room;
		shifted = rdata_q << boff_q;
		bits    = shifted >> (BYTE_BITS - n);
		sbit    = acc_q[5'(w_q - 6'd1)];
		value   = (sgn_q && sbit) ? (acc_q | (32'hFFFF_FFFF << w_q)) : acc_q;
		raddr   = cmd.eval ? start_ptr : rptr_q;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (cmd.finish && (req_q.req_type == REQ_PUSH) && (stat_q == ST_OK)) begin
			mem[tail_q] <= req_q.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (cmd.eval) begin
			w_q    <= w_eff;
			sgn_q  <= sgn && need_fetch;
			pop_q  <= end_pos[5:3];
			noff_q <= end_pos[2:0];
			stat_q <= stat;
			acc_q  <= '0;
			rem_q  <= w_eff;
			boff_q <= sp[2:0];
			rptr_q <= ptr_add(start_ptr, 3'd1);
		end else if (cmd.shift) begin
			acc_q  <= (acc_q << n) | 32'(bits);
			rem_q  <= rem_q - 6'(n);
			boff_q <= '0;
			rptr_q <= ptr_add(rptr_q, 3'd1);
		end
		if (cmd.finish) begin
			rsp_q.field_value <= value;
			rsp_q.status      <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			held_q      <= '0;
			off_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish && (stat_q == ST_OK)) begin
				if (req_q.req_type == REQ_PUSH) begin
					tail_q <= ptr_add(tail_q, 3'd1);
					held_q <= held_q + HW'(1);
				end else begin
					head_q <= ptr_add(head_q, pop_q);
					held_q <= held_q - HW'(pop_q);
					off_q  <= noff_q;
				end
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign st.need_fetch = need_fetch;
	assign st.last_byte  = last;
	assign st.out_free   = !rsp_valid_q || !rsp_stall;
	assign st.fifo_empty = (held_q == '0);
	assign st.partial    = (off_q != 3'd0);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for msb_first_bit_field_reader: directed, then random request words.
// Depends on mbfr_pkg and the design top; a scoreboard class predicts each response word.
`timescale 1ns / 1ps

module tb_top;
	import mbfr_pkg::*;

	localparam int DEPTH     = 8;
	localparam int MAX_BITS  = 32;
	localparam int N_RANDOM  = 800;

	class field_checker;
		logic [7:0] fifo_mem [DEPTH];
		int         head;
		int         tail;
		int         held;
		int         bit_off;
		out_word_t  pending_fields[$];
		int         n_err;
		int         n_req;
		int         n_push;
		int         n_read;
		int         n_full;
		int         n_short;
		int         n_rsp;

		function new();
			head = 0;
			tail = 0;
			held = 0;
			bit_off = 0;
			n_err = 0;
			n_req = 0;
			n_push = 0;
			n_read = 0;
			n_full = 0;
			n_short = 0;
			n_rsp = 0;
			foreach (fifo_mem[i])
				fifo_mem[i] = '0;
		endfunction

		task report(string msg);
			n_err++;
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		function int bytes_held();
			return held;
		endfunction

		function int pending();
			return pending_fields.size();
		endfunction

		function void drop_bytes(int n);
			head = (head + n) % DEPTH;
			held -= n;
		endfunction

		function logic [31:0] take_bits(int start, int width, bit sgn);
			logic [31:0] acc;
			logic        b;
			int          pos;
			acc = '0;
			for (int i = 0; i < width; i++) begin
				pos = start + i;
				b = fifo_mem[(head + pos / 8) % DEPTH][7 - (pos % 8)];
				if (i == 0 && sgn && b)
					acc = '1;
				else
					acc = {acc[30:0], b};
			end
			drop_bytes((start + width) / 8);
			bit_off = (start + width) % 8;
			return acc;
		endfunction

		function out_word_t extract_field(in_word_t w);
			out_word_t r;
			int        wd;
			int        skip;
			r = '0;
			r.status = ST_OK;
			wd = (w.field_width > MAX_BITS) ? MAX_BITS : int'(w.field_width);
			case (w.req_type)
				REQ_PUSH: begin
					if (held >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						fifo_mem[tail] = w.data_byte;
						tail = (tail + 1) % DEPTH;
						held++;
					end
				end
				REQ_UNSIGNED, REQ_SIGNED: begin
					if (wd != 0) begin
						if (wd > held * 8 - bit_off)
							r.status = ST_SHORT;
						else
							r.field_value = take_bits(bit_off, wd, w.req_type == REQ_SIGNED);
					end
				end
				REQ_ALIGN: begin
					if (bit_off != 0) begin
						drop_bytes(1);
						bit_off = 0;
					end
				end
				REQ_ALIGNED_BYTE: begin
					skip = (bit_off != 0) ? 1 : 0;
					if (held < skip + 1) begin
						r.status = ST_SHORT;
					end else begin
						if (skip != 0) begin
							drop_bytes(1);
							bit_off = 0;
						end
						r.field_value = take_bits(0, 8, 1'b0);
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_request(in_word_t w);
			out_word_t e;
			e = extract_field(w);
			n_req++;
			if (w.req_type == REQ_PUSH)
				n_push++;
			if (w.req_type inside {REQ_UNSIGNED, REQ_SIGNED, REQ_ALIGNED_BYTE})
				n_read++;
			if (e.status == ST_FULL)
				n_full++;
			if (e.status == ST_SHORT)
				n_short++;
			pending_fields.push_back(e);
		endfunction

		task check_response(out_word_t r);
			out_word_t e;
			n_rsp++;
			if (pending_fields.size() == 0) begin
				report($sformatf("unexpected word value=%h status=%0d", r.field_value, r.status));
			end else begin
				e = pending_fields.pop_front();
				if (r.field_value !== e.field_value)
					report($sformatf("word %0d field_value %h, want %h",
						n_rsp, r.field_value, e.field_value));
				if (r.status !== e.status)
					report($sformatf("word %0d status %0d, want %0d", n_rsp, r.status, e.status));
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	in_word_t  req;
	logic      rsp_valid;
	logic      rsp_stall;
	out_word_t rsp;

	bit           tx_calm;
	bit           rx_calm;
	field_checker sb;

	msb_first_bit_field_reader #(
		.FIFO_DEPTH     (DEPTH),
		.MAX_FIELD_BITS (MAX_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	function automatic in_word_t mk(logic [2:0] t, logic [7:0] d, logic [5:0] w);
		in_word_t x;
		x.req_type = t;
		x.data_byte = d;
		x.field_width = w;
		return x;
	endfunction

	function automatic logic [5:0] rand_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 6'd0;
		else if (r < 55)
			return 6'($urandom_range(1, 8));
		else if (r < 80)
			return 6'($urandom_range(9, 16));
		else if (r < 95)
			return 6'($urandom_range(17, 32));
		else
			return 6'($urandom_range(33, 63));
	endfunction

	function automatic in_word_t rand_request(int held);
		int       push_pct;
		int       r;
		in_word_t w;
		push_pct = (held < 2) ? 70 : (held > 6) ? 20 : 45;
		w = mk(REQ_PUSH, 8'($urandom_range(0, 255)), rand_width());
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			w.req_type = REQ_PUSH;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 40)
				w.req_type = REQ_UNSIGNED;
			else if (r < 75)
				w.req_type = REQ_SIGNED;
			else if (r < 85)
				w.req_type = REQ_ALIGN;
			else if (r < 96)
				w.req_type = REQ_ALIGNED_BYTE;
			else
				w.req_type = 3'($urandom_range(5, 7));
		end
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		int gap;
		gap = tx_calm ? 0 : idle_len();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	initial begin
		int n;
		rsp_stall = 1'b0;
		wait (arst_n);
		forever begin
			n = rx_calm ? 0 : idle_len();
			repeat (n) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
			end
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		#5ms;
		$display("Timeout with %0d words outstanding", sb.pending());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		in_word_t dir_q[$];
		sb = new();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty buffer: short reads, no-op align, zero width
		dir_q.push_back(mk(REQ_UNSIGNED, 8'h00, 6'd1));
		dir_q.push_back(mk(REQ_ALIGNED_BYTE, 8'hFF, 6'd0));
		dir_q.push_back(mk(REQ_ALIGN, 8'h00, 6'd0));
		dir_q.push_back(mk(REQ_SIGNED, 8'h00, 6'd0));
		// fill, then overflow
		dir_q.push_back(mk(REQ_PUSH, 8'hFF, 6'd63));
		dir_q.push_back(mk(REQ_PUSH, 8'h00, 6'd0));
		dir_q.push_back(mk(REQ_PUSH, 8'hA5, 6'd0));
		dir_q.push_back(mk(REQ_PUSH, 8'h5A, 6'd0));
		dir_q.push_back(mk(REQ_PUSH, 8'h80, 6'd0));
		dir_q.push_back(mk(REQ_PUSH, 8'h7F, 6'd0));
		dir_q.push_back(mk(REQ_PUSH, 8'h01, 6'd0));
		dir_q.push_back(mk(REQ_PUSH, 8'hFE, 6'd0));
		dir_q.push_back(mk(REQ_PUSH, 8'h33, 6'd0));
		dir_q.push_back(mk(REQ_UNSIGNED, 8'h00, 6'd32));
		dir_q.push_back(mk(REQ_SIGNED, 8'h00, 6'd1));
		dir_q.push_back(mk(REQ_ALIGN, 8'h00, 6'd0));
		// oversize width saturates to 32, still short
		dir_q.push_back(mk(REQ_SIGNED, 8'h00, 6'd63));
		dir_q.push_back(mk(REQ_UNSIGNED, 8'h00, 6'd3));
		dir_q.push_back(mk(REQ_ALIGNED_BYTE, 8'h00, 6'd0));
		dir_q.push_back(mk(3'd7, 8'hFF, 6'd63));
		dir_q.push_back(mk(3'd5, 8'h00, 6'd0));
		dir_q.push_back(mk(3'd6, 8'h00, 6'd32));
		dir_q.push_back(mk(REQ_SIGNED, 8'h00, 6'd8));
		dir_q.push_back(mk(REQ_UNSIGNED, 8'h00, 6'd1));
		foreach (dir_q[i])
			send_word(dir_q[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			send_word(rand_request(sb.bytes_held()));
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests: %0d pushes (%0d dropped full), %0d reads (%0d short).",
			sb.n_req, sb.n_push, sb.n_full, sb.n_read, sb.n_short);
		$display("Checked %0d response words, %0d mismatches.", sb.n_rsp, sb.n_err);
		if (sb.n_err == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
design/mbfr_pkg.sv
design/mbfr_ctrl.sv
design/mbfr_datapath.sv
design/msb_first_bit_field_reader.sv
dv/tb_top.sv
